// ===== hdl/mdsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Method descriptor slot parser package
// Shared types, character classes, phase encoding and status codes.
// ----------------------------------------------------------------------------
package mdsp_pkg;

  localparam int SLOT_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [7:0] LIMIT_RESET = 8'd255;

  // descriptor bytes with a meaning of their own
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ARRAY = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CLASS = 8'h4C;
  localparam logic [7:0] CH_LONG  = 8'h4A;
  localparam logic [7:0] CH_DBL   = 8'h44;
  localparam logic [7:0] CH_VOID  = 8'h56;
  localparam logic [7:0] CH_BYTE  = 8'h42;
  localparam logic [7:0] CH_CHAR  = 8'h43;
  localparam logic [7:0] CH_SHORT = 8'h53;
  localparam logic [7:0] CH_BOOL  = 8'h5A;
  localparam logic [7:0] CH_INT   = 8'h49;
  localparam logic [7:0] CH_FLOAT = 8'h46;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY  = 2'd2;

  typedef enum logic [3:0] {
    CLS_OPEN,
    CLS_CLOSE,
    CLS_BASE1,
    CLS_BASE2,
    CLS_CLASS,
    CLS_ARRAY,
    CLS_SEMI,
    CLS_VOID,
    CLS_ZERO,
    CLS_OTHER
  } char_cls_t;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_ARGS,
    PH_ARG_NAME,
    PH_RET,
    PH_RET_ARRAY,
    PH_RET_NAME,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_static;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] arg_slots;
    logic [1:0] ret_slots;
  } out_item_t;

  typedef struct packed {
    char_cls_t cls;
    logic      is_static;
    logic      last;
  } cls_entry_t;

endpackage

`default_nettype wire

// ===== hdl/mdsp_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor byte classifier
// Maps each incoming byte onto the character class the parser acts on.
// ----------------------------------------------------------------------------
module mdsp_classify (
  input  mdsp_pkg::in_item_t   item,
  output mdsp_pkg::cls_entry_t entry
);

  mdsp_pkg::char_cls_t cls;

  always_comb begin
    case (item.char_code)
      mdsp_pkg::CH_OPEN:  cls = mdsp_pkg::CLS_OPEN;
      mdsp_pkg::CH_CLOSE: cls = mdsp_pkg::CLS_CLOSE;
      mdsp_pkg::CH_ARRAY: cls = mdsp_pkg::CLS_ARRAY;
      mdsp_pkg::CH_SEMI:  cls = mdsp_pkg::CLS_SEMI;
      mdsp_pkg::CH_CLASS: cls = mdsp_pkg::CLS_CLASS;
      mdsp_pkg::CH_LONG,
      mdsp_pkg::CH_DBL:   cls = mdsp_pkg::CLS_BASE2;
      mdsp_pkg::CH_VOID:  cls = mdsp_pkg::CLS_VOID;
      mdsp_pkg::CH_BYTE,
      mdsp_pkg::CH_CHAR,
      mdsp_pkg::CH_SHORT,
      mdsp_pkg::CH_BOOL,
      mdsp_pkg::CH_INT,
      mdsp_pkg::CH_FLOAT: cls = mdsp_pkg::CLS_BASE1;
      mdsp_pkg::CH_NUL:   cls = mdsp_pkg::CLS_ZERO;
      default:            cls = mdsp_pkg::CLS_OTHER;
    endcase
  end

  assign entry.cls       = cls;
  assign entry.is_static = item.is_static;
  assign entry.last      = item.last;

endmodule

`default_nettype wire

// ===== hdl/mdsp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Classified byte queue
// Small FIFO between classifier and parser; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module mdsp_queue #(
  parameter int DEPTH = mdsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push,
  input  mdsp_pkg::cls_entry_t        push_data,
  input  wire                         pop,
  output mdsp_pkg::cls_entry_t        head,
  output logic                        not_empty,
  output logic                        not_full,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mdsp_pkg::cls_entry_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = slots_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != CW'(DEPTH));
  assign count     = count_r;

endmodule

`default_nettype wire

// ===== hdl/mdsp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor grammar engine
// Phase machine with slot counters; builds the result on the last byte and
// holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module mdsp_parse #(
  parameter int SLOT_BITS = mdsp_pkg::SLOT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [7:0]            limit,
  input  mdsp_pkg::cls_entry_t  entry,
  input  wire                   entry_valid,
  output logic                  entry_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output mdsp_pkg::out_item_t   out_data
);

  localparam int CW = (SLOT_BITS > 8) ? SLOT_BITS : 8;
  localparam logic [SLOT_BITS-1:0] SLOT_MAX = '1;

  mdsp_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic                 array_pend_r, array_pend_nxt;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;
  logic [1:0]           ret_r, ret_nxt;
  logic [1:0]           ret_step;
  logic                 name_empty_r, name_empty_nxt;
  logic                 out_valid_r, out_valid_nxt;
  mdsp_pkg::out_item_t  out_data_r, out_data_nxt;

  logic [SLOT_BITS-1:0] final_slots;
  logic [CW-1:0]        final_wide;
  logic                 last_pop;

  function automatic logic [SLOT_BITS-1:0] sat_add(input logic [SLOT_BITS-1:0] a,
                                                    input logic [1:0] n);
    logic [SLOT_BITS:0] s;
    s = {1'b0, a} + (SLOT_BITS + 1)'(n);
    sat_add = s[SLOT_BITS] ? SLOT_MAX : s[SLOT_BITS-1:0];
  endfunction

  // a last byte needs room in the output register
  assign entry_pop = entry_valid && (!entry.last || !out_valid_r || out_ready);
  assign last_pop  = entry_pop && entry.last;

  // next phase for the byte at the queue head
  always_comb begin
    phase_step = phase_r;
    case (phase_r)
      mdsp_pkg::PH_OPEN: begin
        phase_step = (entry.cls == mdsp_pkg::CLS_OPEN) ? mdsp_pkg::PH_ARGS
                                                       : mdsp_pkg::PH_ERROR;
      end
      mdsp_pkg::PH_ARGS: begin
        case (entry.cls)
          mdsp_pkg::CLS_CLOSE: begin
            phase_step = array_pend_r ? mdsp_pkg::PH_ERROR : mdsp_pkg::PH_RET;
          end
          mdsp_pkg::CLS_BASE1,
          mdsp_pkg::CLS_BASE2,
          mdsp_pkg::CLS_ARRAY: phase_step = mdsp_pkg::PH_ARGS;
          mdsp_pkg::CLS_CLASS: phase_step = mdsp_pkg::PH_ARG_NAME;
          default:             phase_step = mdsp_pkg::PH_ERROR;
        endcase
      end
      mdsp_pkg::PH_ARG_NAME: begin
        if (entry.cls == mdsp_pkg::CLS_SEMI) begin
          phase_step = name_empty_r ? mdsp_pkg::PH_ERROR : mdsp_pkg::PH_ARGS;
        end else if (entry.cls == mdsp_pkg::CLS_ZERO) begin
          phase_step = mdsp_pkg::PH_ERROR;
        end
      end
      mdsp_pkg::PH_RET: begin
        case (entry.cls)
          mdsp_pkg::CLS_VOID,
          mdsp_pkg::CLS_BASE1,
          mdsp_pkg::CLS_BASE2: phase_step = mdsp_pkg::PH_DONE;
          mdsp_pkg::CLS_CLASS: phase_step = mdsp_pkg::PH_RET_NAME;
          mdsp_pkg::CLS_ARRAY: phase_step = mdsp_pkg::PH_RET_ARRAY;
          default:             phase_step = mdsp_pkg::PH_ERROR;
        endcase
      end
      mdsp_pkg::PH_RET_ARRAY: begin
        case (entry.cls)
          mdsp_pkg::CLS_ARRAY: phase_step = mdsp_pkg::PH_RET_ARRAY;
          mdsp_pkg::CLS_CLASS: phase_step = mdsp_pkg::PH_RET_NAME;
          mdsp_pkg::CLS_BASE1,
          mdsp_pkg::CLS_BASE2: phase_step = mdsp_pkg::PH_DONE;
          default:             phase_step = mdsp_pkg::PH_ERROR;
        endcase
      end
      mdsp_pkg::PH_RET_NAME: begin
        if (entry.cls == mdsp_pkg::CLS_SEMI) begin
          phase_step = name_empty_r ? mdsp_pkg::PH_ERROR : mdsp_pkg::PH_DONE;
        end else if (entry.cls == mdsp_pkg::CLS_ZERO) begin
          phase_step = mdsp_pkg::PH_ERROR;
        end
      end
      default: phase_step = mdsp_pkg::PH_ERROR;
    endcase

    if (!entry_pop) begin
      phase_nxt = phase_r;
    end else if (entry.last) begin
      phase_nxt = mdsp_pkg::PH_OPEN;
    end else begin
      phase_nxt = phase_step;
    end
  end

  // counters and marks
  always_comb begin
    array_pend_nxt = array_pend_r;
    slot_nxt       = slot_r;
    ret_nxt        = ret_r;
    name_empty_nxt = name_empty_r;
    case (phase_r)
      mdsp_pkg::PH_ARGS: begin
        case (entry.cls)
          mdsp_pkg::CLS_BASE1: begin
            slot_nxt       = sat_add(slot_r, 2'd1);
            array_pend_nxt = 1'b0;
          end
          mdsp_pkg::CLS_BASE2: begin
            slot_nxt       = sat_add(slot_r, array_pend_r ? 2'd1 : 2'd2);
            array_pend_nxt = 1'b0;
          end
          mdsp_pkg::CLS_CLASS: begin
            array_pend_nxt = 1'b0;
            name_empty_nxt = 1'b1;
          end
          mdsp_pkg::CLS_ARRAY: array_pend_nxt = 1'b1;
          default: ;
        endcase
      end
      mdsp_pkg::PH_ARG_NAME: begin
        if (entry.cls == mdsp_pkg::CLS_SEMI) begin
          if (!name_empty_r) begin
            slot_nxt = sat_add(slot_r, 2'd1);
          end
        end else if (entry.cls != mdsp_pkg::CLS_ZERO) begin
          name_empty_nxt = 1'b0;
        end
      end
      mdsp_pkg::PH_RET: begin
        case (entry.cls)
          mdsp_pkg::CLS_VOID:  ret_nxt = 2'd0;
          mdsp_pkg::CLS_BASE1: ret_nxt = 2'd1;
          mdsp_pkg::CLS_BASE2: ret_nxt = 2'd2;
          mdsp_pkg::CLS_CLASS: begin
            ret_nxt        = 2'd1;
            name_empty_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      mdsp_pkg::PH_RET_ARRAY: begin
        case (entry.cls)
          mdsp_pkg::CLS_CLASS: begin
            ret_nxt        = 2'd1;
            name_empty_nxt = 1'b1;
          end
          mdsp_pkg::CLS_BASE1,
          mdsp_pkg::CLS_BASE2: ret_nxt = 2'd1;
          default: ;
        endcase
      end
      mdsp_pkg::PH_RET_NAME: begin
        if (entry.cls != mdsp_pkg::CLS_SEMI && entry.cls != mdsp_pkg::CLS_ZERO) begin
          name_empty_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // return slots including this byte, before the end-of-descriptor clear
    ret_step = ret_nxt;

    if (!entry_pop) begin
      array_pend_nxt = array_pend_r;
      slot_nxt       = slot_r;
      ret_nxt        = ret_r;
      name_empty_nxt = name_empty_r;
    end else if (entry.last) begin
      array_pend_nxt = 1'b0;
      slot_nxt       = '0;
      ret_nxt        = 2'd0;
      name_empty_nxt = 1'b1;
    end
  end

  // result; a completing byte never adds argument slots, so slot_r is final,
  // but it may set the return slots itself
  assign final_slots = sat_add(slot_r, {1'b0, !entry.is_static});
  assign final_wide  = CW'(final_slots);

  always_comb begin
    out_data_nxt = out_data_r;
    if (last_pop) begin
      if (phase_step != mdsp_pkg::PH_DONE) begin
        out_data_nxt.status    = mdsp_pkg::STATUS_MALFORMED;
        out_data_nxt.arg_slots = 8'd0;
        out_data_nxt.ret_slots = 2'd0;
      end else begin
        out_data_nxt.status    = (final_wide >= CW'(limit)) ? mdsp_pkg::STATUS_TOO_MANY
                                                            : mdsp_pkg::STATUS_OK;
        out_data_nxt.arg_slots = (final_wide > CW'(8'hFF)) ? 8'hFF : final_wide[7:0];
        out_data_nxt.ret_slots = ret_step;
      end
    end

    if (last_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mdsp_pkg::PH_OPEN;
      array_pend_r <= 1'b0;
      slot_r       <= '0;
      ret_r        <= 2'd0;
      name_empty_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      array_pend_r <= array_pend_nxt;
      slot_r       <= slot_nxt;
      ret_r        <= ret_nxt;
      name_empty_r <= name_empty_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/method_descriptor_slot_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Method descriptor slot parser
// Checks a method descriptor byte stream and reports argument/return slots.
// ----------------------------------------------------------------------------
// Feed one descriptor byte per transfer, with last on the final byte; one
// result per descriptor comes out on the last byte: status, argument slots
// (receiver included unless is_static) and return slots. The block sustains
// one byte per clock while results are taken: the grammar phase machine
// handles each byte at the queue head. A classified byte passes through a
// QUEUE_DEPTH-entry queue; with the queue otherwise empty the parser takes
// the last byte at the next clock edge, later when bytes ahead of it still
// wait in the queue, and the result is offered from that edge on. A result
// waiting in the output register holds back the next last byte at the
// queue head; bytes ahead of it keep flowing. Write cfg_wdata (argument
// slot limit, reset 255) only while no descriptor is in flight.
// ----------------------------------------------------------------------------
module method_descriptor_slot_parser_top #(
  parameter int SLOT_BITS   = mdsp_pkg::SLOT_BITS_DEF,
  parameter int QUEUE_DEPTH = mdsp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  mdsp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output mdsp_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire  [7:0]           cfg_wdata
);

  logic [7:0] limit_r, limit_nxt;

  mdsp_pkg::cls_entry_t in_entry;
  mdsp_pkg::cls_entry_t q_head;
  logic                 q_not_empty;
  logic                 q_not_full;
  logic                 q_pop;
  logic                 q_push;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign limit_nxt = cfg_we ? cfg_wdata : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mdsp_pkg::LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign in_ready = q_not_full;
  assign q_push   = in_valid && q_not_full;

  mdsp_classify u_classify (
    .item  (in_data),
    .entry (in_entry)
  );

  mdsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (in_entry),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full),
    .count     (q_count)
  );

  mdsp_parse #(
    .SLOT_BITS (SLOT_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .limit       (limit_r),
    .entry       (q_head),
    .entry_valid (q_not_empty),
    .entry_pop   (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("byte queue count beyond its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_count != '0)
    else $error("parser popped an empty queue");

  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == mdsp_pkg::STATUS_MALFORMED) |->
      (out_data.arg_slots == 8'd0 && out_data.ret_slots == 2'd0))
    else $error("malformed result carries slot counts");

  a_last_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.last) |=> out_valid)
    else $error("last byte did not produce a result");

endmodule

`default_nettype wire
